// ===== hw/rtl/tcp_segment_checksum_check_defines.svh =====
// assertion macros used by the checker file tcpcs_checker.sv
`ifndef TCP_SEGMENT_CHECKSUM_CHECK_DEFINES_SVH
`define TCP_SEGMENT_CHECKSUM_CHECK_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define TCPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpcs check failed");

// next-cycle implication, quiet while reset is held
`define TCPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpcs check failed");

// implication checked on every edge, reset included
`define TCPCS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("tcpcs check failed");

`endif

// ===== hw/rtl/tcpcs_pkg.sv =====
`default_nettype none

package tcpcs_pkg;

    // one packet byte in
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    // one checksum result out
    typedef struct packed {
        logic [15:0] folded_sum;
        logic        sum_valid;
        logic [1:0]  error_code;
    } t_out_item;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_SHORT  = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    localparam logic [15:0] PROTO_TCP   = 16'h0006;
    localparam logic [3:0]  MIN_IHL     = 4'd5;
    localparam logic [15:0] POS_TOT_HI  = 16'd2;
    localparam logic [15:0] POS_TOT_LO  = 16'd3;
    localparam logic [15:0] POS_ADDR_LO = 16'd12;
    localparam logic [15:0] POS_ADDR_HI = 16'd19;
    localparam logic [15:0] POS_DATA    = 16'd20;
    localparam logic [15:0] POS_MAX     = 16'hffff;
    localparam logic [15:0] SUM_GOOD    = 16'hffff;

    // one's-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {16'd0, s[16]} + {1'b0, s[15:0]};
        return f[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcp_segment_checksum_check.sv =====
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+----------------------------
// in       | to block  | i_in_valid / o_in_ready   | i_in_item  (byte, last flag)
// out      | from block| o_out_valid / i_out_ready | o_out_item (sum, ok, error)
//
// one packet byte is taken every cycle while no stalled result holds the output register;
// the result is offered from the edge that moves the last byte out of the input register
// the rate is set by the checksum adders that each byte passes through once
// reset (i_rst_n low at a clock edge) clears the packet state and both valid flags
// a stalled result holds the output register, the input register then fills and
// o_in_ready drops; both registers refill in the cycle the stall clears
`default_nettype none

module tcp_segment_checksum_check
    import tcpcs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    // input register
    logic      r_in_valid;
    t_in_item  r_in;

    // packet state
    logic [15:0] r_pos, n_pos;
    logic [5:0]  r_hdr, n_hdr;
    logic [15:0] r_tot, n_tot;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_hold, n_hold;
    logic        r_lerr, n_lerr;

    // result register
    logic       r_out_valid;
    t_out_item  r_out, n_out;

    logic advance;
    logic fire;

    // working values for the byte in the input register
    logic [3:0]  ihl;
    logic [15:0] tot_full;
    logic [15:0] tcp_len;
    logic [15:0] sum_hdr;
    logic        in_data;
    logic        add_data;
    logic [16:0] consumed;
    logic [16:0] seg_end;
    logic        add_pad;
    logic [15:0] word;
    logic [15:0] sum_byte;
    logic [1:0]  err;

    // the result register frees when empty or when its item is taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign fire       = r_in_valid && advance;

    always_comb begin
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_tot  = r_tot;
        n_sum  = r_sum;
        n_hold = r_hold;
        n_lerr = r_lerr;

        // header length from the ihl nibble, short values raised to the minimum header
        ihl = (r_in.packet_byte[3:0] < MIN_IHL) ? MIN_IHL : r_in.packet_byte[3:0];

        tot_full = {r_tot[15:8], r_in.packet_byte};
        tcp_len  = tot_full - {10'd0, r_hdr};
        // pseudo-header protocol and tcp length terms, folded in one go
        sum_hdr  = oc_add(oc_add(r_sum, PROTO_TCP), tcp_len);

        // segment bytes: past the fixed header, past the options, inside total length;
        // the header length is a multiple of four so word parity follows byte position
        in_data  = (r_pos >= POS_DATA) && !r_lerr && (r_pos >= {10'd0, r_hdr})
                   && (r_pos < r_tot);
        add_data = 1'b0;

        unique case (1'b1)
            (r_pos == '0): begin
                n_hdr = {ihl, 2'b00};
            end
            (r_pos == POS_TOT_HI): begin
                n_tot = {r_in.packet_byte, 8'd0};
            end
            (r_pos == POS_TOT_LO): begin
                n_tot = tot_full;
                if (tot_full < {10'd0, r_hdr}) begin
                    n_lerr = 1'b1;
                end else begin
                    n_sum = sum_hdr;
                end
            end
            (r_pos >= POS_ADDR_LO && r_pos <= POS_ADDR_HI): begin
                // source and destination addresses
                if (r_pos[0]) begin
                    add_data = 1'b1;
                end else begin
                    n_hold = r_in.packet_byte;
                end
            end
            default: begin
                if (in_data) begin
                    if (r_pos[0]) begin
                        add_data = 1'b1;
                    end else begin
                        n_hold = r_in.packet_byte;
                    end
                end
            end
        endcase

        // odd tail byte on the last item gets a zero low byte;
        // the total length includes a low byte arriving with this item
        consumed = {1'b0, r_pos} + 17'd1;
        seg_end  = (consumed < {1'b0, n_tot}) ? consumed : {1'b0, n_tot};
        add_pad  = r_in.last_byte && !n_lerr && (consumed >= 17'd4)
                   && (seg_end > {11'd0, r_hdr}) && seg_end[0];

        // data word and pad word never fall on the same byte
        word     = add_data ? {r_hold, r_in.packet_byte} : {n_hold, 8'd0};
        sum_byte = oc_add(r_sum, word);
        if (add_data || add_pad) begin
            n_sum = sum_byte;
        end

        if (n_lerr) begin
            err = ERR_LENGTH;
        end else if (consumed < 17'd4 || consumed < {1'b0, n_tot}) begin
            err = ERR_SHORT;
        end else begin
            err = ERR_OK;
        end

        n_out.folded_sum = n_lerr ? 16'd0 : n_sum;
        n_out.error_code = err;
        n_out.sum_valid  = (err == ERR_OK) && (n_sum == SUM_GOOD);

        if (r_in.last_byte) begin
            // back to the start of a packet
            n_pos  = '0;
            n_hdr  = '0;
            n_tot  = '0;
            n_sum  = '0;
            n_hold = '0;
            n_lerr = 1'b0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hdr  <= '0;
            r_tot  <= '0;
            r_sum  <= '0;
            r_hold <= '0;
            r_lerr <= 1'b0;
        end else if (fire) begin
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_tot  <= n_tot;
            r_sum  <= n_sum;
            r_hold <= n_hold;
            r_lerr <= n_lerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && r_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/tcpcs_checker.sv =====
`default_nettype none
`include "tcp_segment_checksum_check_defines.svh"

module tcpcs_checker
    import tcpcs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_item
);

    logic in_take;
    logic out_wait;

    assign in_take  = i_in_valid && i_in_ready && i_in_item.last_byte;
    assign out_wait = i_out_valid && !i_out_ready;

    // a waiting result keeps its payload
    `TCPCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait,
        i_out_valid && $stable(i_out_item))

    // no result right after reset
    `TCPCS_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n), !i_out_valid)

    // a good checksum only comes with no error and an all-ones sum
    `TCPCS_ASSERT_NOW(a_good_sum, i_clk, i_rst_n, i_out_valid && i_out_item.sum_valid,
        i_out_item.error_code == ERR_OK && i_out_item.folded_sum == SUM_GOOD)

    // a length error reports a zero sum
    `TCPCS_ASSERT_NOW(a_len_err, i_clk, i_rst_n,
        i_out_valid && i_out_item.error_code == ERR_LENGTH,
        i_out_item.folded_sum == 16'd0 && !i_out_item.sum_valid)

    // a last byte taken with the output free reaches the result register
    `TCPCS_ASSERT_NEXT(a_latency, i_clk, i_rst_n, in_take && !i_out_valid && i_out_ready,
        ##1 (i_out_valid || !$past(i_out_ready)))

endmodule

bind tcp_segment_checksum_check tcpcs_checker u_tcpcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

// packet byte queue used to build test packets
typedef logic [7:0] t_bytes [$];

class seg_sum_tracker;
    // mirrored packet state
    logic [15:0] pos;
    logic [5:0]  hdr_len;
    logic [15:0] tot_len;
    logic [15:0] run_sum;
    logic [7:0]  hold;
    logic        len_err;

    tcpcs_pkg::t_out_item expected_sums [$];
    int mismatches;
    int predicted;

    function new();
        clear();
        mismatches = 0;
        predicted  = 0;
    endfunction

    function void clear();
        pos     = '0;
        hdr_len = '0;
        tot_len = '0;
        run_sum = '0;
        hold    = '0;
        len_err = 1'b0;
    endfunction

    static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function void fold_in(logic [15:0] w);
        run_sum = ones_add(run_sum, w);
    endfunction

    function void note_byte(tcpcs_pkg::t_in_item it);
        int unsigned p;
        int unsigned r;
        int unsigned used;
        int unsigned stop;
        logic [7:0]  b;
        logic [3:0]  ihl;
        logic [1:0]  err;
        tcpcs_pkg::t_out_item res;
        p = pos;
        b = it.packet_byte;
        if (p == 0) begin
            ihl = b[3:0];
            if (ihl < tcpcs_pkg::MIN_IHL) ihl = tcpcs_pkg::MIN_IHL;
            hdr_len = {ihl, 2'b00};
        end else if (p == tcpcs_pkg::POS_TOT_HI) begin
            tot_len = {b, 8'h00};
        end else if (p == tcpcs_pkg::POS_TOT_LO) begin
            tot_len[7:0] = b;
            if (tot_len < {10'd0, hdr_len}) begin
                len_err = 1'b1;
            end else begin
                fold_in(tcpcs_pkg::PROTO_TCP);
                fold_in(tot_len - {10'd0, hdr_len});
            end
        end else if (p >= tcpcs_pkg::POS_ADDR_LO && p <= tcpcs_pkg::POS_ADDR_HI) begin
            if (p % 2 == 0) hold = b;
            else fold_in({hold, b});
        end
        if (p >= tcpcs_pkg::POS_DATA && !len_err && p >= hdr_len && p < tot_len) begin
            r = p - hdr_len;
            if (r % 2 == 0) hold = b;
            else fold_in({hold, b});
        end
        if (!it.last_byte) begin
            if (pos != tcpcs_pkg::POS_MAX) pos = pos + 16'd1;
            return;
        end
        used = p + 1;
        if (len_err) begin
            res.folded_sum = '0;
            res.sum_valid  = 1'b0;
            res.error_code = tcpcs_pkg::ERR_LENGTH;
        end else begin
            if (used > tcpcs_pkg::POS_TOT_LO) begin
                stop = (used < tot_len) ? used : tot_len;
                // odd segment byte still waiting gets a zero low byte
                if (stop > hdr_len && ((stop - hdr_len) % 2 == 1)) fold_in({hold, 8'h00});
            end
            err = (used <= tcpcs_pkg::POS_TOT_LO || used < tot_len) ?
                  tcpcs_pkg::ERR_SHORT : tcpcs_pkg::ERR_OK;
            res.folded_sum = run_sum;
            res.sum_valid  = (err == tcpcs_pkg::ERR_OK && run_sum == tcpcs_pkg::SUM_GOOD);
            res.error_code = err;
        end
        expected_sums.push_back(res);
        predicted++;
        clear();
    endfunction

    function void match_result(tcpcs_pkg::t_out_item got);
        tcpcs_pkg::t_out_item want;
        if (expected_sums.size() == 0) begin
            $error("unexpected result item sum %h valid %b error %0d",
                   got.folded_sum, got.sum_valid, got.error_code);
            mismatches++;
            return;
        end
        want = expected_sums.pop_front();
        if (got.folded_sum !== want.folded_sum) begin
            $error("folded_sum expected %h got %h", want.folded_sum, got.folded_sum);
            mismatches++;
        end
        if (got.sum_valid !== want.sum_valid) begin
            $error("sum_valid expected %b got %b", want.sum_valid, got.sum_valid);
            mismatches++;
        end
        if (got.error_code !== want.error_code) begin
            $error("error_code expected %0d got %0d", want.error_code, got.error_code);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction
endclass

module testbench;
    import tcpcs_pkg::*;

    // clock, reset and the block's ports; the driven inputs are known from time zero
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // idling knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // long receiver hold-off used to back the block up
    logic hold_req = 1'b0;
    logic hold_off = 1'b0;

    int random_bytes = 0;

    seg_sum_tracker tracker = new();

    tcp_segment_checksum_check dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // every accepted byte goes through the predictor
    always @(posedge clk) begin
        if (rst_n && in_valid && o_in_ready) tracker.note_byte(in_item);
    end

    // receiver: random stalls, forced low during a hold-off, results checked on accept
    always @(posedge clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        if (rst_n && o_out_valid && out_ready) tracker.match_result(o_out_item);
    end

    // hold-off counter in cycles, started by a request from the stimulus
    always @(posedge clk) begin
        if (hold_req && !hold_off) begin
            hold_off <= 1'b1;
            hold_req <= 1'b0;
            repeat (80) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // offer one byte, idling beforehand at random, return right after the accepting edge
    task automatic offer_byte(input logic [7:0] b, input logic last);
        t_in_item nxt;
        nxt.packet_byte = b;
        nxt.last_byte   = last;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= nxt;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic send_packet(input t_bytes pkt);
        foreach (pkt[i]) offer_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // ipv4/tcp packet; when asked and the segment holds a word, checksum word patched so the sum folds to all ones
    function automatic t_bytes make_segment(int ihl_nib, int tcp_len, bit fix_sum, int trail);
        t_bytes      pkt;
        int          hdr;
        int          at;
        logic [15:0] tot;
        logic [15:0] acc;
        hdr = ((ihl_nib < MIN_IHL) ? MIN_IHL : ihl_nib) * 4;
        tot = 16'(hdr + tcp_len);
        for (int i = 0; i < hdr + tcp_len + trail; i++) pkt.push_back(8'($urandom));
        pkt[0] = {4'($urandom), 4'(ihl_nib)};
        pkt[2] = tot[15:8];
        pkt[3] = tot[7:0];
        if (fix_sum && tcp_len >= 2) begin
            // the tcp checksum field when the segment is long enough, else the first word
            at = hdr + ((tcp_len >= 18) ? 16 : 0);
            pkt[at]     = 8'h00;
            pkt[at + 1] = 8'h00;
            acc = '0;
            for (int i = 12; i < 20; i += 2)
                acc = oc_add(acc, {pkt[i], pkt[i + 1]});
            acc = oc_add(acc, PROTO_TCP);
            acc = oc_add(acc, 16'(tcp_len));
            for (int r = 0; r < tcp_len; r += 2)
                acc = oc_add(acc,
                          {pkt[hdr + r], (r + 1 < tcp_len) ? pkt[hdr + r + 1] : 8'h00});
            acc = ~acc;
            pkt[at]     = acc[15:8];
            pkt[at + 1] = acc[7:0];
        end
        return pkt;
    endfunction

    function automatic t_bytes with_total(t_bytes pkt, logic [15:0] tot);
        pkt[2] = tot[15:8];
        pkt[3] = tot[7:0];
        return pkt;
    endfunction

    // mostly whole segments, patched or not at random, then truncated ones, short totals and plain noise
    task automatic random_packet();
        t_bytes pkt;
        int     kind;
        int     ihl;
        int     hdr;
        int     trail;
        int     n;
        kind  = $urandom_range(99);
        ihl   = ($urandom_range(99) < 70) ? 5 : $urandom_range(15);
        hdr   = ((ihl < MIN_IHL) ? MIN_IHL : ihl) * 4;
        trail = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
        pkt   = make_segment(ihl, $urandom_range(0, 30), $urandom_range(1), trail);
        if (kind >= 65 && kind < 80) begin
            n   = $urandom_range(1, pkt.size() - 1);
            pkt = pkt[0:n - 1];
        end else if (kind >= 80 && kind < 90) begin
            pkt = with_total(pkt, 16'($urandom_range(0, hdr - 1)));
        end else if (kind >= 90) begin
            pkt = {};
            n   = $urandom_range(1, 12);
            repeat (n) pkt.push_back(8'($urandom));
        end
        send_packet(pkt);
        random_bytes += pkt.size();
    endtask

    task automatic run_phase(int idle, int stall, int n_bytes, int n_results);
        int start_bytes;
        int start_results;
        idle_pct      = idle;
        stall_pct     = stall;
        start_bytes   = random_bytes;
        start_results = tracker.predicted;
        while (random_bytes - start_bytes < n_bytes ||
               tracker.predicted - start_results < n_results)
            random_packet();
    endtask

    initial begin
        t_bytes pkt;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed packets, no idling
        send_packet('{8'h00});                                     // ends at the first byte
        send_packet('{8'hff, 8'hff, 8'hff});                       // ends before the total is known
        pkt = make_segment(5, 0, 0, 0);
        send_packet(pkt[0:3]);                                     // ends right after the total
        send_packet(make_segment(0, 0, 0, 0));                     // zero ihl, empty segment
        send_packet(make_segment(15, 7, 1, 0));                    // largest header, odd segment
        send_packet(with_total(make_segment(5, 4, 0, 0), 16'd0));  // zero total length
        send_packet(with_total(make_segment(6, 17, 0, 0), 16'hffff)); // short with odd byte pending
        send_packet(make_segment(5, 11, 1, 5));                    // trailing bytes ignored
        pkt = {};
        repeat (61) pkt.push_back(8'hff);                          // all ones, max total
        send_packet(pkt);
        send_packet(with_total(make_segment(5, 0, 0, 0), 16'd19)); // total one below header
        send_packet(make_segment(4, 4, 1, 0));                     // ihl below five
        send_packet(make_segment(5, 18, 1, 0));                    // checksum in its own field

        // receiver holds off while tiny packets keep coming, so the block backs up
        hold_req <= 1'b1;
        repeat (16) begin
            pkt = {};
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            send_packet(pkt);
        end

        // random traffic under each idling pattern
        run_phase(0, 0, 230, 6);
        run_phase(83, 0, 230, 6);
        run_phase(0, 83, 230, 6);
        run_phase(13, 13, 230, 6);

        // drain: stop offering, let every result out, then a few spare cycles
        in_valid <= 1'b0;
        stall_pct = 0;
        while (tracker.pending() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire
